### src/jmpp_pkg.sv
package jmpp_pkg;

   // Display geometry
   localparam int unsigned DISPLAY_WIDTH  = 240;
   localparam int unsigned DISPLAY_HEIGHT = 240;

   // Configuration register indexes
   localparam logic [2:0] CSR_MCU_BLOCKS_ACROSS = 3'd0;
   localparam logic [2:0] CSR_MCU_BLOCKS_DOWN   = 3'd1;
   localparam logic [2:0] CSR_IMAGE_WIDTH       = 3'd2;
   localparam logic [2:0] CSR_IMAGE_HEIGHT      = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_X          = 3'd4;
   localparam logic [2:0] CSR_ORIGIN_Y          = 3'd5;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Image coordinate width: 13-bit MCU origin plus up to 15 inside the MCU
   localparam int unsigned IMG_WIDTH = 14;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pixel_address;
      logic [15:0] pixel_word;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]         mcu_blocks_across;
      logic [1:0]         mcu_blocks_down;
      logic [11:0]        image_width;
      logic [11:0]        image_height;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } cfg_type;

   // Pixel in image coordinates, between the position and clip stages
   typedef struct packed {
      logic [IMG_WIDTH-1:0] img_x;
      logic [IMG_WIDTH-1:0] img_y;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
   } place_type;

endpackage

### src/jmpp_csr.sv
module jmpp_csr
   import jmpp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MCU_BLOCKS_ACROSS: cfg_in.mcu_blocks_across = csr_write_data[1:0];
            CSR_MCU_BLOCKS_DOWN:   cfg_in.mcu_blocks_down   = csr_write_data[1:0];
            CSR_IMAGE_WIDTH:       cfg_in.image_width       = csr_write_data[11:0];
            CSR_IMAGE_HEIGHT:      cfg_in.image_height      = csr_write_data[11:0];
            CSR_ORIGIN_X:          cfg_in.origin_x          = $signed(csr_write_data);
            CSR_ORIGIN_Y:          cfg_in.origin_y          = $signed(csr_write_data);
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mcu_blocks_across <= 2'd1;
         cfg_ff.mcu_blocks_down   <= 2'd1;
         cfg_ff.image_width       <= '0;
         cfg_ff.image_height      <= '0;
         cfg_ff.origin_x          <= '0;
         cfg_ff.origin_y          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/jmpp_position.sv
module jmpp_position
   import jmpp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            place_valid,
   input  logic            place_stall,
   output place_type       place
);

   logic [12:0] mcu_x_ff, mcu_x_in;
   logic [12:0] mcu_y_ff, mcu_y_in;
   logic [1:0]  block_ff, block_in;
   logic [2:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic        valid_ff, valid_in;
   place_type   place_ff, place_in;

   logic        load;
   logic        accept;
   logic        across2;
   logic        down2;
   logic [12:0] cur_x;
   logic [12:0] cur_y;
   logic [1:0]  cur_block;
   logic [2:0]  cur_row;
   logic [2:0]  cur_col;
   logic        bcol;
   logic [1:0]  brow;
   logic [2:0]  block_count;
   logic [IMG_WIDTH-1:0] next_x_sum;
   logic [IMG_WIDTH-1:0] next_y_sum;

   // Stage handshake: load when empty or when the clip stage takes the item
   assign load      = !valid_ff || !place_stall;
   assign req_stall = !load;
   assign accept    = req_valid && load;

   assign across2 = cfg.mcu_blocks_across[1];
   assign down2   = cfg.mcu_blocks_down[1];

   // Apply frame start before placing this pixel
   always_comb begin
      if (req_payload.frame_start) begin
         cur_x     = '0;
         cur_y     = '0;
         cur_block = '0;
         cur_row   = '0;
         cur_col   = '0;
      end else begin
         cur_x     = mcu_x_ff;
         cur_y     = mcu_y_ff;
         cur_block = block_ff;
         cur_row   = row_ff;
         cur_col   = col_ff;
      end
   end

   // Block position inside the MCU
   assign bcol = across2 ? cur_block[0] : 1'b0;
   assign brow = across2 ? {1'b0, cur_block[1]} : cur_block;

   always_comb begin
      place_in.img_x = {1'b0, cur_x} + IMG_WIDTH'({bcol, cur_col});
      place_in.img_y = {1'b0, cur_y} + IMG_WIDTH'({brow, cur_row});
      place_in.red   = req_payload.red;
      place_in.green = req_payload.green;
      place_in.blue  = req_payload.blue;
   end

   assign block_count = across2 ? (down2 ? 3'd4 : 3'd2) : (down2 ? 3'd2 : 3'd1);
   assign next_x_sum  = {1'b0, cur_x} + (across2 ? IMG_WIDTH'(16) : IMG_WIDTH'(8));
   assign next_y_sum  = {1'b0, cur_y} + (down2 ? IMG_WIDTH'(16) : IMG_WIDTH'(8));

   // Advance column, row, block, then MCU
   always_comb begin
      mcu_x_in = mcu_x_ff;
      mcu_y_in = mcu_y_ff;
      block_in = block_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (accept) begin
         mcu_x_in = cur_x;
         mcu_y_in = cur_y;
         block_in = cur_block;
         row_in   = cur_row;
         col_in   = cur_col + 3'd1;
         if (cur_col == 3'd7) begin
            row_in = cur_row + 3'd1;
            if (cur_row == 3'd7) begin
               if (({1'b0, cur_block} + 3'd1) < block_count) begin
                  block_in = cur_block + 2'd1;
               end else begin
                  block_in = '0;
                  mcu_x_in = next_x_sum[12:0];
                  if (next_x_sum >= {2'b0, cfg.image_width}) begin
                     mcu_x_in = '0;
                     if (!cur_y[12]) begin
                        mcu_y_in = next_y_sum[12:0];
                     end
                  end
               end
            end
         end
      end
   end

   assign valid_in = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mcu_x_ff <= '0;
         mcu_y_ff <= '0;
         block_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         mcu_x_ff <= mcu_x_in;
         mcu_y_ff <= mcu_y_in;
         block_ff <= block_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the payload unless a new transaction loads
   always_ff @(posedge clock) begin
      if (accept) begin
         place_ff <= place_in;
      end
   end

   assign place_valid = valid_ff;
   assign place       = place_ff;

   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.frame_start) |=>
         (valid_ff && place_ff.img_x == '0 && place_ff.img_y == '0))
      else $error("frame start did not place pixel at image origin");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && place_stall) |=> (valid_ff && $stable(place_ff)))
      else $error("stalled pixel changed in position stage");

   a_row_steps_on_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_payload.frame_start && col_ff != 3'd7) |=>
         (row_ff == $past(row_ff)))
      else $error("row advanced without column wrap");

endmodule

### src/jmpp_clip.sv
module jmpp_clip
   import jmpp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            place_valid,
   output logic            place_stall,
   input  place_type       place,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic               load;
   logic               visible;
   logic signed [17:0] sx;
   logic signed [17:0] sy;
   logic [31:0]        addr_full;

   // Output register loads when empty or when the receiver takes it
   assign load        = !valid_ff || !rsp_stall;
   assign place_stall = !load;

   // Display coordinate at full width
   assign sx = 18'(cfg.origin_x) + $signed({4'b0, place.img_x});
   assign sy = 18'(cfg.origin_y) + $signed({4'b0, place.img_y});

   // Clip to the image and to the display
   assign visible = (place.img_x < {2'b0, cfg.image_width}) &&
                    (place.img_y < {2'b0, cfg.image_height}) &&
                    !sx[17] && (sx < $signed(18'(DISPLAY_WIDTH))) &&
                    !sy[17] && (sy < $signed(18'(DISPLAY_HEIGHT)));

   assign addr_full = 32'(unsigned'(sy)) * 32'(DISPLAY_WIDTH) + 32'(unsigned'(sx));

   // Pack RGB565 and swap bytes
   always_comb begin
      rsp_in.pixel_address = addr_full[15:0];
      rsp_in.pixel_word    = {place.green[4:2], place.blue[7:3],
                              place.red[7:3], place.green[7:5]};
   end

   assign valid_in = load ? (place_valid && visible) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### src/jpeg_mcu_pixel_placer_unit.sv
// JPEG MCU pixel placer.
// Decoded pixels enter on the req_ channel one transaction per pixel, in MCU
// buffer order (8x8 blocks, row-major, one or two blocks across and down).
// Each visible pixel leaves on the rsp_ channel as a framebuffer address and
// a byte-swapped RGB565 word; pixels outside the image or the display are
// dropped and produce no transaction.
// The csr_ port writes the MCU shape, image size and display origin; write it
// only while no pixel is in flight.
// An accepted pixel passes through a register for the image position and
// one for the clipped output.
// Throughput: one pixel per cycle while the receiver does not stall.
// Reset clears the MCU position and loads the register defaults; a pixel with
// frame_start set restarts the position at the image origin.
// When the receiver stalls, the output register holds its transaction and the
// position stage, if empty, can still take one more pixel before req_stall rises.
module jpeg_mcu_pixel_placer_unit
   import jmpp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type   cfg;
   logic      place_valid;
   logic      place_stall;
   place_type place;

   jmpp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   jmpp_position u_position (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .place_valid (place_valid),
      .place_stall (place_stall),
      .place       (place)
   );

   jmpp_clip u_clip (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .place_valid (place_valid),
      .place_stall (place_stall),
      .place       (place),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
